FILE: src/microwire_serial_eeprom_assert.svh
// Assertion macros for the Microwire serial EEPROM block.
// Included by the top level; expects signals named clk and rst_n in scope.
`ifndef MICROWIRE_SERIAL_EEPROM_ASSERT_SVH
`define MICROWIRE_SERIAL_EEPROM_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSE_ASSERT_SAME(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MSE_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: src/mse_pkg.sv
// Shared types and constants for the Microwire serial EEPROM block.
// Depends on nothing; used by the top level microwire_serial_eeprom.
package mse_pkg;

    // One bus access word and one result word.
    typedef struct packed {
        logic        kind;
        logic [23:0] address;
        logic [7:0]  write_data;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       dirty;
    } rsp_t;

    // Bus access kinds.
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // Fixed register addresses on the byte bus.
    localparam logic [23:0] ADR_DO = 24'hF14001;
    localparam logic [23:0] ADR_DI = 24'hF14801;
    localparam logic [23:0] ADR_CS = 24'hF15001;

    // Command opcodes.
    localparam logic [1:0] OP_EXT   = 2'b00;
    localparam logic [1:0] OP_WRITE = 2'b01;
    localparam logic [1:0] OP_READ  = 2'b10;
    localparam logic [1:0] OP_ERASE = 2'b11;

    // Extended commands, chosen by the top two address bits.
    localparam logic [1:0] EXT_EWDS = 2'b00;
    localparam logic [1:0] EXT_WRAL = 2'b01;
    localparam logic [1:0] EXT_ERAL = 2'b10;
    localparam logic [1:0] EXT_EWEN = 2'b11;

    // Last step index of a chained dispatch on one DI write.
    localparam logic [2:0] STEP_LAST = 3'd7;

    // Command sequencer states.
    typedef enum logic [19:0] {
        SQ_START   = 20'h00001,
        SQ_OPA     = 20'h00002,
        SQ_OPB     = 20'h00004,
        SQ_C0      = 20'h00008,
        SQ_C1      = 20'h00010,
        SQ_C2      = 20'h00020,
        SQ_C3      = 20'h00040,
        SQ_EXT     = 20'h00080,
        SQ_ADDR    = 20'h00100,
        SQ_EWDS    = 20'h00200,
        SQ_WRAL    = 20'h00400,
        SQ_ERAL    = 20'h00800,
        SQ_EWEN    = 20'h01000,
        SQ_WRAL_GO = 20'h02000,
        SQ_DATA    = 20'h04000,
        SQ_BUSY    = 20'h08000,
        SQ_WR_DATA = 20'h10000,
        SQ_WR_GO   = 20'h20000,
        SQ_RD_OUT  = 20'h40000,
        SQ_ER_GO   = 20'h80000
    } seq_t;

    // Access controller states.
    typedef enum logic [3:0] {
        CT_IDLE   = 4'b0001,
        CT_STEP   = 4'b0010,
        CT_RDWAIT = 4'b0100,
        CT_DONE   = 4'b1000
    } ctrl_t;

endpackage

FILE: src/microwire_serial_eeprom.sv
// Top level of the Microwire serial EEPROM block behind a byte bus.
// Depends on mse_pkg and on the macro header microwire_serial_eeprom_assert.svh.
//
// Each bus access word is accepted only while the controller is idle and gives
// exactly one result word. A read or write of CS, a read of DO outside a READ
// and any other address pass from idle through the DONE state into the output
// register, and the controller returns to idle as that register loads. A DO
// read while a READ shifts out first passes through the RDWAIT state for the
// registered read port of the word store. A DI write runs the sequencer steps
// it dispatches in the STEP state; chained steps run one per cycle through the
// single sequencer step logic, at most 8 per access, before the DONE state. A
// finished word waits in the output register while the next access is taken;
// while that register is held by a stalled word, the next finished access
// waits in place and no new word is taken. The store reads as all ones after
// reset through per-word valid bits and a fill value register, so no clearing
// pass is needed, and WRAL and ERAL only clear the valid bits and set the fill
// value.
`include "microwire_serial_eeprom_assert.svh"

module microwire_serial_eeprom #(
    parameter int WORDS     = 64,
    parameter int WORD_BITS = 16,
    parameter int ADDR_BITS = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  mse_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output mse_pkg::rsp_t rsp
);

    localparam int IDX_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int AW_MAX = (ADDR_BITS > IDX_W) ? ADDR_BITS : IDX_W;
    localparam int ABL_W  = $clog2(ADDR_BITS + 1);
    localparam int DBL_W  = $clog2(WORD_BITS + 1);
    localparam logic [WORD_BITS-1:0] WORD_ONES = '1;

    // Controller and sequencer state.
    mse_pkg::ctrl_t ctrl_reg, ctrl_next;
    mse_pkg::seq_t  seq_reg, seq_next;
    mse_pkg::seq_t  ret_reg, ret_next;
    logic [1:0]           opcode_reg, opcode_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [ABL_W-1:0]     abl_reg, abl_next;
    logic [WORD_BITS-1:0] data_reg, data_next;
    logic [DBL_W-1:0]     dbl_reg, dbl_next;
    logic                 we_reg, we_next;
    logic                 chain_reg, chain_next;
    logic                 dirty_reg, dirty_next;
    logic [2:0]           guard_reg, guard_next;
    logic                 bit_reg, bit_next;
    logic                 rdbit_reg, rdbit_next;

    // Output register.
    mse_pkg::rsp_t rsp_reg;
    logic          rsp_valid_reg;

    // Word store, valid bits and fill value.
    logic [WORD_BITS-1:0] store_reg [WORDS];
    logic [WORDS-1:0]     valid_reg;
    logic [WORD_BITS-1:0] fill_reg;
    logic [WORD_BITS-1:0] rd_word_reg;
    logic                 rd_hit_reg;
    logic                 rd_inrange_reg;

    // Store access controls from the sequencer.
    logic                 chain;
    logic                 mem_wr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 fill_go;
    logic [WORD_BITS-1:0] fill_val;
    logic                 rd_issue;
    logic                 out_load;

    // Store index and range check from the shifted address.
    logic [AW_MAX-1:0]    addr_wide;
    logic [IDX_W-1:0]     mem_idx;
    logic                 addr_in_range;
    logic [WORD_BITS-1:0] word_sel;
    logic [WORD_BITS-1:0] word_shift;

    assign addr_wide     = AW_MAX'(addr_reg);
    assign mem_idx       = addr_wide[IDX_W-1:0];
    assign addr_in_range = (32'(addr_reg) < 32'(WORDS));

    // Word seen by a serial read: unmapped addresses read as all ones.
    assign word_sel   = !rd_inrange_reg ? WORD_ONES : (rd_hit_reg ? rd_word_reg : fill_reg);
    assign word_shift = word_sel >> dbl_reg;

    assign out_load  = (ctrl_reg == mse_pkg::CT_DONE) && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = (ctrl_reg != mse_pkg::CT_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Access decode and one sequencer step per cycle.
    always_comb
    begin
        ctrl_next   = ctrl_reg;
        seq_next    = seq_reg;
        ret_next    = ret_reg;
        opcode_next = opcode_reg;
        addr_next   = addr_reg;
        abl_next    = abl_reg;
        data_next   = data_reg;
        dbl_next    = dbl_reg;
        we_next     = we_reg;
        chain_next  = chain_reg;
        dirty_next  = dirty_reg;
        guard_next  = guard_reg;
        bit_next    = bit_reg;
        rdbit_next  = rdbit_reg;
        chain       = 1'b0;
        mem_wr      = 1'b0;
        mem_wdata   = data_reg;
        fill_go     = 1'b0;
        fill_val    = data_reg;
        rd_issue    = 1'b0;

        unique case (ctrl_reg)
            mse_pkg::CT_IDLE:
            begin
                if (req_valid)
                begin
                    rdbit_next = 1'b0;
                    ctrl_next  = mse_pkg::CT_DONE;
                    priority if (req.address == mse_pkg::ADR_CS)
                    begin
                        // Chip select restarts the sequencer and enables writes.
                        seq_next    = mse_pkg::SQ_START;
                        opcode_next = '0;
                        ret_next    = mse_pkg::SQ_START;
                        addr_next   = '0;
                        abl_next    = ABL_W'(ADDR_BITS);
                        data_next   = '0;
                        dbl_next    = DBL_W'(WORD_BITS);
                        we_next     = 1'b1;
                    end
                    else if (req.kind == mse_pkg::KIND_READ && req.address == mse_pkg::ADR_DO)
                    begin
                        priority if (seq_reg == mse_pkg::SQ_BUSY)
                        begin
                            // Busy reads low once, then the part is ready.
                            seq_next = mse_pkg::SQ_START;
                        end
                        else if (seq_reg == mse_pkg::SQ_RD_OUT)
                        begin
                            dbl_next  = dbl_reg - DBL_W'(1);
                            rd_issue  = 1'b1;
                            ctrl_next = mse_pkg::CT_RDWAIT;
                        end
                        else
                        begin
                            rdbit_next = 1'b1;
                        end
                    end
                    else if (req.kind == mse_pkg::KIND_WRITE && req.address == mse_pkg::ADR_DI)
                    begin
                        bit_next   = req.write_data[0];
                        guard_next = '0;
                        ctrl_next  = mse_pkg::CT_STEP;
                    end
                    else
                    begin
                        rdbit_next = 1'b0;
                    end
                end
            end

            mse_pkg::CT_STEP:
            begin
                unique case (seq_reg)
                    mse_pkg::SQ_START:
                    begin
                        seq_next = mse_pkg::SQ_OPA;
                    end
                    mse_pkg::SQ_OPA:
                    begin
                        opcode_next = {bit_reg, 1'b0};
                        seq_next    = mse_pkg::SQ_OPB;
                    end
                    mse_pkg::SQ_OPB:
                    begin
                        opcode_next = {opcode_reg[1], bit_reg};
                        chain_next  = 1'b0;
                        chain       = 1'b1;
                        unique case ({opcode_reg[1], bit_reg})
                            mse_pkg::OP_EXT:   seq_next = mse_pkg::SQ_C0;
                            mse_pkg::OP_WRITE: seq_next = mse_pkg::SQ_C1;
                            mse_pkg::OP_READ:  seq_next = mse_pkg::SQ_C2;
                            mse_pkg::OP_ERASE: seq_next = mse_pkg::SQ_C3;
                            default:           seq_next = mse_pkg::SQ_C0;
                        endcase
                    end
                    mse_pkg::SQ_C0, mse_pkg::SQ_C1, mse_pkg::SQ_C2, mse_pkg::SQ_C3:
                    begin
                        // Start collecting the address field.
                        seq_next  = mse_pkg::SQ_ADDR;
                        abl_next  = ABL_W'(ADDR_BITS);
                        addr_next = '0;
                        unique case (seq_reg)
                            mse_pkg::SQ_C0:
                            begin
                                ret_next   = mse_pkg::SQ_EXT;
                                chain_next = 1'b1;
                            end
                            mse_pkg::SQ_C1:
                            begin
                                ret_next   = mse_pkg::SQ_WR_DATA;
                                chain_next = 1'b1;
                            end
                            mse_pkg::SQ_C2:
                            begin
                                ret_next  = mse_pkg::SQ_RD_OUT;
                                dbl_next  = DBL_W'(WORD_BITS);
                                data_next = '0;
                            end
                            default:
                            begin
                                ret_next   = mse_pkg::SQ_ER_GO;
                                chain_next = 1'b1;
                            end
                        endcase
                    end
                    mse_pkg::SQ_EXT:
                    begin
                        chain = 1'b1;
                        unique case (addr_reg[ADDR_BITS-1 -: 2])
                            mse_pkg::EXT_EWDS: seq_next = mse_pkg::SQ_EWDS;
                            mse_pkg::EXT_WRAL: seq_next = mse_pkg::SQ_WRAL;
                            mse_pkg::EXT_ERAL: seq_next = mse_pkg::SQ_ERAL;
                            mse_pkg::EXT_EWEN: seq_next = mse_pkg::SQ_EWEN;
                            default:           seq_next = mse_pkg::SQ_EWDS;
                        endcase
                    end
                    mse_pkg::SQ_EWDS:
                    begin
                        we_next  = 1'b0;
                        seq_next = mse_pkg::SQ_START;
                    end
                    mse_pkg::SQ_EWEN:
                    begin
                        we_next  = 1'b1;
                        seq_next = mse_pkg::SQ_START;
                    end
                    mse_pkg::SQ_WRAL, mse_pkg::SQ_WR_DATA:
                    begin
                        // Start collecting the data field.
                        seq_next   = mse_pkg::SQ_DATA;
                        dbl_next   = DBL_W'(WORD_BITS);
                        data_next  = '0;
                        chain_next = 1'b1;
                        ret_next   = (seq_reg == mse_pkg::SQ_WRAL) ? mse_pkg::SQ_WRAL_GO
                                                                    : mse_pkg::SQ_WR_GO;
                    end
                    mse_pkg::SQ_WRAL_GO:
                    begin
                        if (we_reg)
                        begin
                            fill_go    = 1'b1;
                            fill_val   = data_reg;
                            dirty_next = 1'b1;
                        end
                        seq_next = mse_pkg::SQ_BUSY;
                    end
                    mse_pkg::SQ_ERAL:
                    begin
                        // Erase all leaves the dirty flag alone.
                        if (we_reg)
                        begin
                            fill_go  = 1'b1;
                            fill_val = WORD_ONES;
                        end
                        seq_next = mse_pkg::SQ_BUSY;
                    end
                    mse_pkg::SQ_WR_GO:
                    begin
                        if (we_reg)
                        begin
                            mem_wr     = addr_in_range;
                            mem_wdata  = data_reg;
                            dirty_next = 1'b1;
                        end
                        seq_next = mse_pkg::SQ_BUSY;
                    end
                    mse_pkg::SQ_ER_GO:
                    begin
                        mem_wr    = we_reg && addr_in_range;
                        mem_wdata = WORD_ONES;
                        seq_next  = mse_pkg::SQ_BUSY;
                    end
                    mse_pkg::SQ_DATA:
                    begin
                        data_next = {data_reg[WORD_BITS-2:0], bit_reg};
                        dbl_next  = dbl_reg - DBL_W'(1);
                        if (dbl_reg == DBL_W'(1))
                        begin
                            seq_next = ret_reg;
                            chain    = chain_reg;
                        end
                    end
                    mse_pkg::SQ_ADDR:
                    begin
                        addr_next = {addr_reg[ADDR_BITS-2:0], bit_reg};
                        abl_next  = abl_reg - ABL_W'(1);
                        if (abl_reg == ABL_W'(1))
                        begin
                            seq_next = ret_reg;
                            chain    = chain_reg;
                        end
                    end
                    default:
                    begin
                        // Busy or shifting out: the bit counts as a start bit.
                        seq_next = mse_pkg::SQ_OPA;
                    end
                endcase

                guard_next = guard_reg + 3'd1;
                if (!chain || guard_reg == mse_pkg::STEP_LAST)
                begin
                    ctrl_next = mse_pkg::CT_DONE;
                end
            end

            mse_pkg::CT_RDWAIT:
            begin
                // Serial read bit, MSB first; idle after the last one.
                rdbit_next = word_shift[0];
                if (dbl_reg == '0)
                begin
                    seq_next = mse_pkg::SQ_START;
                end
                ctrl_next = mse_pkg::CT_DONE;
            end

            mse_pkg::CT_DONE:
            begin
                if (out_load)
                begin
                    ctrl_next = mse_pkg::CT_IDLE;
                end
            end

            default:
            begin
                ctrl_next = mse_pkg::CT_IDLE;
            end
        endcase
    end

    // Control and sequencer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg   <= mse_pkg::CT_IDLE;
            seq_reg    <= mse_pkg::SQ_START;
            ret_reg    <= mse_pkg::SQ_START;
            opcode_reg <= '0;
            addr_reg   <= '0;
            abl_reg    <= ABL_W'(ADDR_BITS);
            data_reg   <= '0;
            dbl_reg    <= DBL_W'(WORD_BITS);
            we_reg     <= 1'b0;
            chain_reg  <= 1'b0;
            dirty_reg  <= 1'b0;
            guard_reg  <= '0;
            bit_reg    <= 1'b0;
            rdbit_reg  <= 1'b0;
        end
        else
        begin
            ctrl_reg   <= ctrl_next;
            seq_reg    <= seq_next;
            ret_reg    <= ret_next;
            opcode_reg <= opcode_next;
            addr_reg   <= addr_next;
            abl_reg    <= abl_next;
            data_reg   <= data_next;
            dbl_reg    <= dbl_next;
            we_reg     <= we_next;
            chain_reg  <= chain_next;
            dirty_reg  <= dirty_next;
            guard_reg  <= guard_next;
            bit_reg    <= bit_next;
            rdbit_reg  <= rdbit_next;
        end
    end

    // Word store with one write port and a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            store_reg[mem_idx] <= mem_wdata;
        end
        if (rd_issue)
        begin
            rd_word_reg    <= store_reg[mem_idx];
            rd_hit_reg     <= valid_reg[mem_idx];
            rd_inrange_reg <= addr_in_range;
        end
    end

    // Valid bits and fill value; a word that is not valid reads as the fill value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            fill_reg  <= WORD_ONES;
        end
        else if (fill_go)
        begin
            valid_reg <= '0;
            fill_reg  <= fill_val;
        end
        else if (mem_wr)
        begin
            valid_reg[mem_idx] <= 1'b1;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            rsp_reg.read_data <= {7'b0, rdbit_reg};
            rsp_reg.dirty     <= dirty_reg;
        end
    end

    // Checks on the controller and the dirty flag.
    `MSE_ASSERT_SAME(a_rdwait_in_read, ctrl_reg == mse_pkg::CT_RDWAIT, seq_reg == mse_pkg::SQ_RD_OUT, "store read outside a READ shift-out")
    `MSE_ASSERT_NEXT(a_done_delivers, out_load, rsp_valid_reg && ctrl_reg == mse_pkg::CT_IDLE, "finished word not placed in output register")
    `MSE_ASSERT_NEXT(a_dirty_sticky, dirty_reg, dirty_reg, "dirty flag cleared")

endmodule
